// File: sv/mfd_pkg.sv
// Shared sizes, store layout, command codes and pipeline control type for the
// flap-decision perceptron. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

    localparam int INPUT_COUNT   = 4;
    localparam int HIDDEN_COUNT  = 4;
    localparam int FRACTION_BITS = 12;

    localparam int VAL_W   = 16;
    localparam int IDX_W   = 5;
    localparam int ONE     = 1 << FRACTION_BITS;
    localparam int VAL_MAX = 32767;
    localparam int VAL_MIN = -32768;

    localparam int STORE_DEPTH = INPUT_COUNT * HIDDEN_COUNT + 2 * HIDDEN_COUNT + 1;
    localparam int HB_BASE     = INPUT_COUNT * HIDDEN_COUNT;
    localparam int OW_BASE     = INPUT_COUNT * HIDDEN_COUNT + HIDDEN_COUNT;
    localparam int OB_IDX      = INPUT_COUNT * HIDDEN_COUNT + 2 * HIDDEN_COUNT;

    localparam int PROD_W = 2 * VAL_W;
    localparam int PSUM_W = PROD_W + $clog2(INPUT_COUNT) + 1;
    localparam int SUM_W  = PSUM_W + 1;
    localparam int H_W    = FRACTION_BITS + 2;
    localparam int M_W    = VAL_W + H_W;

    localparam int GROUP   = 4;
    localparam int GROUPS  = (HIDDEN_COUNT + GROUP - 1) / GROUP;
    localparam int GSUM_W  = M_W + 3;
    localparam int OSUM_W  = GSUM_W + $clog2(GROUPS) + 2;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic so;
    } t_stage_en;

endpackage

`default_nettype wire

// File: sv/mlp_4_4_1_flap_decision.sv
// Top level of the flap-decision perceptron: weight store, stream ports,
// pipeline control, hidden-neuron lanes and output merge. Depends on mfd_pkg,
// mfd_lane and mfd_merge.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tuser: cmd; tdata: weight_index, weight_value, feature_0..3
//  m_axis    out        tdata: flap, logit
//
// The block takes one beat per cycle unless the output stalls. An evaluation
// runs through stages s1 to s5 and stage so; a weight load is written at once
// and gives no result. Each lane has one multiplier per feature and one for
// its output weight, all used once per beat. Reset clears the weight store and the
// valid flags. A stage waits only when the stage after it is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module mlp_4_4_1_flap_decision
    import mfd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // weight_index, weight_value, feature_0, feature_1, feature_2, feature_3
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // flap, logit
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic signed [VAL_W-1:0] r_store [STORE_DEPTH];
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;

    t_stage_en               stage_en;
    t_cmd                    cmd;
    logic [IDX_W-1:0]        w_idx;
    logic signed [VAL_W-1:0] w_val;
    logic signed [VAL_W-1:0] x [INPUT_COUNT];
    logic signed [M_W-1:0]   lane_m [HIDDEN_COUNT];
    logic signed [VAL_W-1:0] logit;
    logic                    flap;
    logic                    in_beat;

    assign cmd   = t_cmd'(s_axis_tuser[0]);
    assign w_idx = s_axis_tdata[IDX_W-1:0];
    assign w_val = s_axis_tdata[IDX_W +: VAL_W];

    genvar gi;
    generate
        for (gi = 0; gi < INPUT_COUNT; gi++) begin : g_feat
            assign x[gi] = s_axis_tdata[IDX_W + VAL_W * (gi + 1) +: VAL_W];
        end
    endgenerate

    always_comb begin
        stage_en.so = !r_vo || m_axis_tready;
        stage_en.s5 = !r_v5 || stage_en.so;
        stage_en.s4 = !r_v4 || stage_en.s5;
        stage_en.s3 = !r_v3 || stage_en.s4;
        stage_en.s2 = !r_v2 || stage_en.s3;
        stage_en.s1 = !r_v1 || stage_en.s2;
    end

    assign s_axis_tready = stage_en.s1;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= '0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (in_beat && cmd == CMD_LOAD) begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    if (int'(w_idx) == k) begin
                        r_store[k] <= w_val;
                    end
                end
            end
            if (stage_en.s1) begin
                r_v1 <= s_axis_tvalid && cmd == CMD_EVAL;
            end
            if (stage_en.s2) begin
                r_v2 <= r_v1;
            end
            if (stage_en.s3) begin
                r_v3 <= r_v2;
            end
            if (stage_en.s4) begin
                r_v4 <= r_v3;
            end
            if (stage_en.s5) begin
                r_v5 <= r_v4;
            end
            if (stage_en.so) begin
                r_vo <= r_v5;
            end
        end
    end

    genvar gj;
    generate
        for (gj = 0; gj < HIDDEN_COUNT; gj++) begin : g_lane
            logic signed [VAL_W-1:0] lane_w [INPUT_COUNT];

            for (gi = 0; gi < INPUT_COUNT; gi++) begin : g_w
                assign lane_w[gi] = r_store[gj * INPUT_COUNT + gi];
            end

            mfd_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (stage_en),
                .i_x    (x),
                .i_w    (lane_w),
                .i_bias (r_store[HB_BASE + gj]),
                .i_w2   (r_store[OW_BASE + gj]),
                .o_m    (lane_m[gj])
            );
        end
    endgenerate

    mfd_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_m     (lane_m),
        .i_b2    (r_store[OB_IDX]),
        .o_logit (logit),
        .o_flap  (flap)
    );

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {(OUT_TDATA_W - VAL_W - 1)'(0), logit, flap};

endmodule

`default_nettype wire

// File: sv/mfd_lane.sv
// One hidden-neuron lane: products, dot-product sum, floor and hard tanh,
// then the output-weight product. Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfd_lane
    import mfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_stage_en               i_en,
    input  wire logic signed [VAL_W-1:0] i_x [INPUT_COUNT],
    input  wire logic signed [VAL_W-1:0] i_w [INPUT_COUNT],
    input  wire logic signed [VAL_W-1:0] i_bias,
    input  wire logic signed [VAL_W-1:0] i_w2,
    output logic signed [M_W-1:0]        o_m
);

    logic signed [PROD_W-1:0] r_p [INPUT_COUNT];
    logic signed [VAL_W-1:0]  r_bias1, r_bias2;
    logic signed [VAL_W-1:0]  r_w2_1, r_w2_2, r_w2_3;
    logic signed [PSUM_W-1:0] r_psum;
    logic signed [H_W-1:0]    r_h;
    logic signed [M_W-1:0]    r_m;

    logic signed [PSUM_W-1:0] n_psum;
    logic signed [SUM_W-1:0]  s_full;
    logic signed [SUM_W-1:0]  s_floor;
    logic signed [H_W-1:0]    n_h;

    always_comb begin
        n_psum = '0;
        for (int i = 0; i < INPUT_COUNT; i++) begin
            n_psum = n_psum + PSUM_W'(r_p[i]);
        end
    end

    always_comb begin
        s_full  = SUM_W'(r_psum) + (SUM_W'(r_bias2) <<< FRACTION_BITS);
        s_floor = s_full >>> FRACTION_BITS;
        if (s_floor > SUM_W'(ONE)) begin
            n_h = H_W'(ONE);
        end else if (s_floor < SUM_W'(-ONE)) begin
            n_h = H_W'(-ONE);
        end else begin
            n_h = H_W'(s_floor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < INPUT_COUNT; i++) begin
                r_p[i] <= i_w[i] * i_x[i];
            end
            r_bias1 <= i_bias;
            r_w2_1  <= i_w2;
        end
        if (i_en.s2) begin
            r_psum  <= n_psum;
            r_bias2 <= r_bias1;
            r_w2_2  <= r_w2_1;
        end
        if (i_en.s3) begin
            r_h    <= n_h;
            r_w2_3 <= r_w2_2;
        end
        if (i_en.s4) begin
            r_m <= M_W'(r_w2_3 * r_h);
        end
    end

    assign o_m = r_m;

endmodule

`default_nettype wire

// File: sv/mfd_merge.sv
// Output neuron: sums the lane products in groups, adds the output bias,
// floors, saturates and sets the flap bit. Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfd_merge
    import mfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_stage_en               i_en,
    input  wire logic signed [M_W-1:0]   i_m [HIDDEN_COUNT],
    input  wire logic signed [VAL_W-1:0] i_b2,
    output logic signed [VAL_W-1:0]      o_logit,
    output logic                         o_flap
);

    logic signed [VAL_W-1:0]  r_b2_1, r_b2_2, r_b2_3, r_b2_4, r_b2_5;
    logic signed [GSUM_W-1:0] r_gsum [GROUPS];
    logic signed [VAL_W-1:0]  r_logit;
    logic                     r_flap;

    logic signed [GSUM_W-1:0] n_gsum [GROUPS];
    logic signed [OSUM_W-1:0] o_full;
    logic signed [OSUM_W-1:0] o_floor;
    logic signed [VAL_W-1:0]  n_logit;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_gsum[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < HIDDEN_COUNT) begin
                    n_gsum[g] = n_gsum[g] + GSUM_W'(i_m[g * GROUP + k]);
                end
            end
        end
    end

    always_comb begin
        o_full = OSUM_W'(r_b2_5) <<< FRACTION_BITS;
        for (int g = 0; g < GROUPS; g++) begin
            o_full = o_full + OSUM_W'(r_gsum[g]);
        end
        o_floor = o_full >>> FRACTION_BITS;
        if (o_floor > OSUM_W'(VAL_MAX)) begin
            n_logit = VAL_W'(VAL_MAX);
        end else if (o_floor < OSUM_W'(VAL_MIN)) begin
            n_logit = VAL_W'(VAL_MIN);
        end else begin
            n_logit = VAL_W'(o_floor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_b2_1 <= i_b2;
        end
        if (i_en.s2) begin
            r_b2_2 <= r_b2_1;
        end
        if (i_en.s3) begin
            r_b2_3 <= r_b2_2;
        end
        if (i_en.s4) begin
            r_b2_4 <= r_b2_3;
        end
        if (i_en.s5) begin
            r_gsum <= n_gsum;
            r_b2_5 <= r_b2_4;
        end
        if (i_en.so) begin
            r_logit <= n_logit;
            r_flap  <= (n_logit > 0);
        end
    end

    assign o_logit = r_logit;
    assign o_flap  = r_flap;

endmodule

`default_nettype wire
